// ----- design/smtp_body_dot_stuffer_defines.svh -----
// ----------------------------------------------------------------------------
// smtp_body_dot_stuffer_defines
// Assertion macros used by the checker file of the dot stuffer.
// ----------------------------------------------------------------------------
`ifndef SMTP_BODY_DOT_STUFFER_DEFINES_SVH
`define SMTP_BODY_DOT_STUFFER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sds_pkg.sv -----
// ----------------------------------------------------------------------------
// sds_pkg
// Types and constants of the SMTP body dot stuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

  localparam int JOB_BYTES = 5;
  localparam int CNT_W     = 3;
  localparam int JOB_DEPTH = 4;
  localparam int JOB_AW    = 2;
  localparam int JOB_CNT_W = JOB_AW + 1;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOM  = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]               cnt;
    logic [JOB_BYTES-1:0][7:0]      bytes;
  } job_t;

endpackage

`default_nettype wire

// ----- design/sds_front.sv -----
// ----------------------------------------------------------------------------
// sds_front
// Classifies each input item against the line state and builds the byte job.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_front import sds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       req_type,
  input  logic [7:0] in_byte,
  output logic       job_push,
  output job_t       job
);

  logic ls_r, ls_nxt;
  logic crh_r, crh_nxt;

  always_comb begin
    job     = '0;
    ls_nxt  = ls_r;
    crh_nxt = crh_r;
    if (req_type == REQ_EOM) begin
      if (crh_r || !ls_r) begin
        job.cnt      = CNT_W'(5);
        job.bytes[0] = CH_CR;
        job.bytes[1] = CH_LF;
        job.bytes[2] = CH_DOT;
        job.bytes[3] = CH_CR;
        job.bytes[4] = CH_LF;
      end else begin
        job.cnt      = CNT_W'(3);
        job.bytes[0] = CH_DOT;
        job.bytes[1] = CH_CR;
        job.bytes[2] = CH_LF;
      end
      ls_nxt  = 1'b1;
      crh_nxt = 1'b0;
    end else if (crh_r) begin
      job.bytes[0] = CH_CR;
      if (in_byte == CH_LF) begin
        job.cnt      = CNT_W'(2);
        job.bytes[1] = CH_LF;
        ls_nxt       = 1'b1;
        crh_nxt      = 1'b0;
      end else if (in_byte == CH_CR) begin
        job.cnt = CNT_W'(1);
        ls_nxt  = 1'b0;
        crh_nxt = 1'b1;
      end else begin
        job.cnt      = CNT_W'(2);
        job.bytes[1] = in_byte;
        ls_nxt       = 1'b0;
        crh_nxt      = 1'b0;
      end
    end else begin
      if (in_byte == CH_LF) begin
        job.cnt      = CNT_W'(2);
        job.bytes[0] = CH_CR;
        job.bytes[1] = CH_LF;
        ls_nxt       = 1'b1;
      end else if (in_byte == CH_CR) begin
        crh_nxt = 1'b1;
      end else if (in_byte == CH_DOT && ls_r) begin
        job.cnt      = CNT_W'(2);
        job.bytes[0] = CH_DOT;
        job.bytes[1] = CH_DOT;
        ls_nxt       = 1'b0;
      end else begin
        job.cnt      = CNT_W'(1);
        job.bytes[0] = in_byte;
        ls_nxt       = 1'b0;
      end
    end
  end

  assign job_push = accept && (job.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ls_r  <= 1'b1;
      crh_r <= 1'b0;
    end else if (accept) begin
      ls_r  <= ls_nxt;
      crh_r <= crh_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sds_job_fifo.sv -----
// ----------------------------------------------------------------------------
// sds_job_fifo
// Short queue of byte jobs between the classifier and the serializer.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_job_fifo import sds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t wr_job,
  input  logic pop,
  output job_t rd_job,
  output logic empty,
  output logic full
);

  job_t                 mem_r [JOB_DEPTH];
  logic [JOB_AW-1:0]    wr_ptr_r;
  logic [JOB_AW-1:0]    rd_ptr_r;
  logic [JOB_CNT_W-1:0] cnt_r;
  logic                 do_push;
  logic                 do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == JOB_CNT_W'(JOB_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_job  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/sds_back.sv -----
// ----------------------------------------------------------------------------
// sds_back
// Shifts job bytes out one per cycle, while the output is popped or empty, into the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sds_back import sds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fifo_empty,
  input  job_t       fifo_job,
  output logic       fifo_pop,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  logic [JOB_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic                      ov_r, ov_nxt;
  logic [7:0]                ob_r, ob_nxt;
  logic                      ol_r, ol_nxt;
  logic                      adv;
  logic                      load_ok;

  assign adv     = !ov_r || pop;
  assign load_ok = (rem_r == '0) || (adv && rem_r == CNT_W'(1));

  always_comb begin
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    ov_nxt    = ov_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    fifo_pop  = 1'b0;
    if (adv) begin
      if (rem_r != '0) begin
        ov_nxt    = 1'b1;
        ob_nxt    = bytes_r[0];
        ol_nxt    = (rem_r == CNT_W'(1));
        bytes_nxt = bytes_r >> 8;
        rem_nxt   = rem_r - 1'b1;
      end else begin
        ov_nxt = 1'b0;
      end
    end
    if (load_ok && !fifo_empty) begin
      fifo_pop  = 1'b1;
      bytes_nxt = fifo_job.bytes;
      rem_nxt   = fifo_job.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      rem_r <= rem_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
  end

  assign empty           = !ov_r;
  assign out_byte        = ob_r;
  assign out_last_of_run = ol_r;

endmodule

`default_nettype wire

// ----- design/smtp_body_dot_stuffer.sv -----
// ----------------------------------------------------------------------------
// smtp_body_dot_stuffer
// SMTP DATA body encoder: CRLF normalization, dot-stuffing, terminator.
// ----------------------------------------------------------------------------
// An item is taken every cycle while full is low; full rises only when the
// four-entry job queue is full. Each item yields zero to five result bytes
// (a data byte mostly one, a doubled dot or line end two, end of message
// three or five), and the serializer sends one byte per clock while the
// receiver pops, so the sustained rate is set by the output side. The first
// byte of an item passes through the job queue, the serializer's shift
// register and the result output register before it can be popped.
`default_nettype none

module smtp_body_dot_stuffer import sds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic       in_req_type,
  input  logic [7:0] in_byte,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);

  logic accept;
  logic job_push;
  job_t job;
  logic fifo_pop;
  logic fifo_empty;
  job_t fifo_job;

  assign accept = push && !full;

  sds_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .req_type (in_req_type),
    .in_byte  (in_byte),
    .job_push (job_push),
    .job      (job)
  );

  sds_job_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (job_push),
    .wr_job (job),
    .pop    (fifo_pop),
    .rd_job (fifo_job),
    .empty  (fifo_empty),
    .full   (full)
  );

  sds_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_empty      (fifo_empty),
    .fifo_job        (fifo_job),
    .fifo_pop        (fifo_pop),
    .pop             (pop),
    .empty           (empty),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- design/sds_checker.sv -----
// ----------------------------------------------------------------------------
// sds_checker
// Port-level checks of the dot stuffer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "smtp_body_dot_stuffer_defines.svh"

module sds_checker import sds_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       in_req_type,
  input logic [7:0] in_byte,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last_of_run
);

  logic       beat;
  logic [7:0] prev_r;
  logic       unused_in;

  assign beat      = pop && !empty;
  assign unused_in = push ^ full ^ in_req_type ^ (^in_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= CH_LF;
    end else if (beat) begin
      prev_r <= out_byte;
    end
  end

  `SDS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(out_byte) && $stable(out_last_of_run), "result changed while stalled")
  `SDS_ASSERT_NOW(a_lf_after_cr, beat && out_byte == CH_LF, prev_r == CH_CR, "LF sent without CR")
  `SDS_ASSERT_NOW(a_line_dot, beat && out_byte == CH_DOT && prev_r == CH_LF, !out_last_of_run || unused_in != unused_in, "dot at line start not stuffed")

endmodule

bind smtp_body_dot_stuffer sds_checker u_chk (.*);

`default_nettype wire

// ----- verif/smtp_body_dot_stuffer_chk.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smtp_body_dot_stuffer_chk
// Watches both queue-style channels of the dot stuffer, predicts the SMTP
// DATA stream from each accepted input beat and compares every popped byte
// and its last-of-run flag against the oldest predicted byte.
// ----------------------------------------------------------------------------

module smtp_body_dot_stuffer_chk import sds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  logic       in_req_type,
  input  logic [7:0] in_byte,
  input  logic       empty,
  input  logic       pop,
  input  logic [7:0] out_byte,
  input  logic       out_last_of_run,
  output int         fail_count,
  output int         pending,
  output int         items_seen,
  output int         msgs_seen,
  output int         bytes_checked
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_beat_t;

  stream_beat_t data_stream_q[$];
  stream_beat_t want;
  logic         line_start;
  logic         cr_waiting;

  initial begin
    fail_count    = 0;
    pending       = 0;
    items_seen    = 0;
    msgs_seen     = 0;
    bytes_checked = 0;
    line_start    = 1'b1;
    cr_waiting    = 1'b0;
  end

  function automatic void encode_item(input logic req, input logic [7:0] b);
    logic [7:0] outb[$];
    logic       consumed;
    stream_beat_t beat;
    consumed = 1'b0;
    if (req == REQ_EOM) begin
      if (cr_waiting || !line_start) begin
        outb.push_back(CH_CR);
        outb.push_back(CH_LF);
      end
      outb.push_back(CH_DOT);
      outb.push_back(CH_CR);
      outb.push_back(CH_LF);
      line_start = 1'b1;
      cr_waiting = 1'b0;
    end else begin
      if (cr_waiting) begin
        cr_waiting = 1'b0;
        outb.push_back(CH_CR);
        if (b == CH_LF) begin
          outb.push_back(CH_LF);
          line_start = 1'b1;
          consumed   = 1'b1;
        end else begin
          line_start = 1'b0;
        end
      end
      if (!consumed) begin
        if (b == CH_LF) begin
          outb.push_back(CH_CR);
          outb.push_back(CH_LF);
          line_start = 1'b1;
        end else if (b == CH_CR) begin
          cr_waiting = 1'b1;
        end else if (b == CH_DOT && line_start) begin
          outb.push_back(CH_DOT);
          outb.push_back(CH_DOT);
          line_start = 1'b0;
        end else begin
          outb.push_back(b);
          line_start = 1'b0;
        end
      end
    end
    for (int i = 0; i < outb.size(); i++) begin
      beat.data = outb[i];
      beat.last = (i == outb.size() - 1);
      data_stream_q.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      data_stream_q.delete();
      line_start = 1'b1;
      cr_waiting = 1'b0;
    end else begin
      if (push && !full) begin
        encode_item(in_req_type, in_byte);
        items_seen++;
        if (in_req_type == REQ_EOM) msgs_seen++;
      end
      if (pop && !empty) begin
        bytes_checked++;
        if (data_stream_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected beat: byte=%02h last=%0b", $realtime, out_byte,
                     out_last_of_run);
        end else begin
          want = data_stream_q.pop_front();
          if (out_byte !== want.data || out_last_of_run !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] mismatch: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                       $realtime, want.data, want.last, out_byte, out_last_of_run);
          end
        end
      end
    end
    pending = data_stream_q.size();
  end

endmodule

// ----- verif/smtp_body_dot_stuffer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smtp_body_dot_stuffer_tb
// Drives the dot stuffer with directed corner cases and random messages,
// with random gaps on both sides and one long receiver hold-off so the
// block backs up and stalls its input. The checker does all prediction.
// ----------------------------------------------------------------------------

module smtp_body_dot_stuffer_tb;
  import sds_pkg::*;

  localparam int NUM_ITEMS   = 330;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 200000;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       push        = 1'b0;
  logic       in_req_type = REQ_DATA;
  logic [7:0] in_byte     = 8'h00;
  logic       pop         = 1'b0;
  logic       full;
  logic       empty;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  int   fail_count, pending, items_seen, msgs_seen, bytes_checked;
  int   sent      = 0;
  int   hold_left = 0;
  logic calm      = 1'b0;
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;

  smtp_body_dot_stuffer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_byte         (in_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  smtp_body_dot_stuffer_chk chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_req_type     (in_req_type),
    .in_byte         (in_byte),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .fail_count      (fail_count),
    .pending         (pending),
    .items_seen      (items_seen),
    .msgs_seen       (msgs_seen),
    .bytes_checked   (bytes_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // receiver: random gaps, one long hold-off, no gaps while calm
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      pop       <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (calm) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(99) >= 36);
    end
  end

  task automatic offer_item(input logic req, input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        push    <= 1'b0;
        in_byte <= 8'($urandom);
        @(posedge clk);
      end
    end
    push        <= 1'b1;
    in_req_type <= req;
    in_byte     <= b;
    do @(posedge clk); while (full);
    sent++;
    calm     <= (sent >= 150 && sent < 210);
    hold_req <= hold_req || (sent >= 60);
  endtask

  function automatic logic [7:0] pick_body_byte();
    case ($urandom_range(9))
      0:       return CH_CR;
      1:       return CH_LF;
      2:       return CH_DOT;
      3:       return 8'($urandom);
      default: return 8'($urandom_range(126, 32));
    endcase
  endfunction

  initial begin
    int len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty body, then dot handling, CR resolution, NUL and all-ones bytes
    offer_item(REQ_EOM,  8'h00);
    offer_item(REQ_DATA, CH_DOT);
    offer_item(REQ_DATA, 8'h41);
    offer_item(REQ_DATA, CH_DOT);
    offer_item(REQ_DATA, CH_CR);
    offer_item(REQ_DATA, CH_LF);
    offer_item(REQ_DATA, 8'h00);
    offer_item(REQ_DATA, CH_CR);
    offer_item(REQ_DATA, 8'h78);
    offer_item(REQ_DATA, CH_LF);
    offer_item(REQ_DATA, CH_CR);
    offer_item(REQ_DATA, CH_CR);
    offer_item(REQ_DATA, CH_LF);
    offer_item(REQ_DATA, CH_CR);
    offer_item(REQ_DATA, CH_DOT);
    offer_item(REQ_DATA, 8'hFF);
    offer_item(REQ_DATA, CH_LF);
    offer_item(REQ_DATA, CH_DOT);
    offer_item(REQ_EOM,  8'hFF);
    offer_item(REQ_DATA, 8'h7A);
    offer_item(REQ_DATA, CH_CR);
    offer_item(REQ_EOM,  8'h55);
    offer_item(REQ_DATA, CH_LF);
    offer_item(REQ_EOM,  8'hAA);

    // random messages, mostly well formed with CRLF lines
    while (sent < NUM_ITEMS) begin
      len = $urandom_range(12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(9) == 0) begin
          offer_item(REQ_DATA, CH_CR);
          offer_item(REQ_DATA, CH_LF);
        end else begin
          offer_item(REQ_DATA, pick_body_byte());
        end
      end
      offer_item(REQ_EOM, 8'($urandom));
    end
    push <= 1'b0;

    do @(negedge clk); while (pending != 0);
    repeat (20) @(posedge clk);

    $display("Covered %0d input beats in %0d messages; %0d output beats compared.",
             items_seen, msgs_seen, bytes_checked);
    $display("Included corner cases, random gaps and a %0d-cycle receiver hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
